>>> rtl/ssd_pkg.sv
package ssd_pkg;

	localparam int DEF_MAX_SAMPLES = 65536;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int MODE_W   = 2;
	localparam int SAMPLE_W = 16;
	localparam int DEV_W    = 24;
	localparam int FRAC_BITS = 8;

	localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_FIN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIN     = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_FEW = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0]          mode;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [DEV_W-1:0] deviation;
		logic             status;
	} result_t;

endpackage

>>> rtl/ssd_core.sv
module ssd_core #(
	parameter int CW   = $clog2(ssd_pkg::DEF_MAX_SAMPLES + 1),
	parameter int SUMW = ssd_pkg::DEF_SAMPLE_BITS + CW,
	parameter int SQW  = 2 * ssd_pkg::DEF_SAMPLE_BITS + CW - 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        take,
	input  logic [CW-1:0]               n,
	input  logic [SQW-1:0]              sqsum,
	input  logic [SUMW-1:0]             summag,
	output logic                        done,
	output logic [ssd_pkg::DEV_W-1:0]   dev
);

	localparam int DW    = 2 * CW;
	localparam int PRODW = CW + SQW;
	localparam int NUMW  = PRODW + 2 * ssd_pkg::FRAC_BITS;
	localparam int XW    = 2 * ssd_pkg::DEV_W;
	localparam int QW    = (NUMW > XW) ? NUMW : XW;
	localparam int RW    = ssd_pkg::DEV_W + 1;
	localparam int UW0   = (PRODW > DW + 1) ? PRODW : DW + 1;
	localparam int UW    = (UW0 > RW + 2) ? UW0 : RW + 2;
	localparam int CNTW  = $clog2(QW + 1);

	typedef enum logic [7:0] {
		C_IDLE = 8'b0000_0001,
		C_MULD = 8'b0000_0010,
		C_MULN = 8'b0000_0100,
		C_MULS = 8'b0000_1000,
		C_SUB  = 8'b0001_0000,
		C_DIV  = 8'b0010_0000,
		C_ROOT = 8'b0100_0000,
		C_DONE = 8'b1000_0000
	} cstate_t;

	cstate_t                     state_q;
	logic [CNTW-1:0]             cnt_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               nm1_q;
	logic [SQW-1:0]              sq_q;
	logic [SUMW-1:0]             mag_q;
	logic [SUMW-1:0]             msc_q;
	logic [DW-1:0]               d_q;
	logic [UW-1:0]               acc_q;
	logic [UW-1:0]               b_q;
	logic [DW-1:0]               rem_q;
	logic [QW-1:0]               quo_q;
	logic [RW-1:0]               srem_q;
	logic [ssd_pkg::DEV_W-1:0]   root_q;
	logic                        sat_q;

	// shared add/subtract unit
	logic [UW-1:0] op_a;
	logic [UW-1:0] op_b;
	logic          op_sub;
	logic [UW:0]   alu;
	logic          alu_ge;
	logic          last;
	logic [RW+1:0] rsh;

	assign alu    = {1'b0, op_a} + (op_sub ? ~{1'b0, op_b} : {1'b0, op_b})
		+ {{UW{1'b0}}, op_sub};
	assign alu_ge = ~alu[UW];
	assign last   = (cnt_q == CNTW'(1));
	assign rsh    = {srem_q, quo_q[XW-1:XW-2]};

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		unique case (state_q)
			C_MULD: begin
				op_a = UW'({d_q, 1'b0});
				op_b = nm1_q[CW-1] ? UW'(n_q) : '0;
			end
			C_MULN: begin
				op_a = {acc_q[UW-2:0], 1'b0};
				op_b = n_q[CW-1] ? UW'(sq_q) : '0;
			end
			C_MULS: begin
				op_a = {b_q[UW-2:0], 1'b0};
				op_b = msc_q[SUMW-1] ? UW'(mag_q) : '0;
			end
			C_SUB: begin
				op_a   = acc_q;
				op_b   = b_q;
				op_sub = 1'b1;
			end
			C_DIV: begin
				op_a   = UW'({rem_q, quo_q[QW-1]});
				op_b   = UW'(d_q);
				op_sub = 1'b1;
			end
			C_ROOT: begin
				op_a   = UW'(rsh);
				op_b   = UW'({root_q, 2'b01});
				op_sub = 1'b1;
			end
			default: begin
				op_a   = '0;
				op_b   = '0;
				op_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MULD;
						cnt_q   <= CNTW'(CW);
					end
				end
				C_MULD: begin
					cnt_q <= cnt_q - 1'b1;
					if (last) begin
						state_q <= C_MULN;
						cnt_q   <= CNTW'(CW);
					end
				end
				C_MULN: begin
					cnt_q <= cnt_q - 1'b1;
					if (last) begin
						state_q <= C_MULS;
						cnt_q   <= CNTW'(SUMW);
					end
				end
				C_MULS: begin
					cnt_q <= cnt_q - 1'b1;
					if (last) begin
						state_q <= C_SUB;
					end
				end
				C_SUB: begin
					state_q <= C_DIV;
					cnt_q   <= CNTW'(QW);
				end
				C_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (last) begin
						state_q <= C_ROOT;
						cnt_q   <= CNTW'(ssd_pkg::DEV_W);
					end
				end
				C_ROOT: begin
					cnt_q <= cnt_q - 1'b1;
					if (last) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					if (take) begin
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				n_q    <= n;
				nm1_q  <= n - 1'b1;
				sq_q   <= sqsum;
				mag_q  <= summag;
				msc_q  <= summag;
				d_q    <= '0;
				acc_q  <= '0;
				b_q    <= '0;
			end
			C_MULD: begin
				d_q   <= alu[DW-1:0];
				nm1_q <= {nm1_q[CW-2:0], 1'b0};
			end
			C_MULN: begin
				acc_q <= alu[UW-1:0];
				n_q   <= {n_q[CW-2:0], 1'b0};
			end
			C_MULS: begin
				b_q   <= alu[UW-1:0];
				msc_q <= {msc_q[SUMW-2:0], 1'b0};
			end
			C_SUB: begin
				quo_q <= QW'({alu[PRODW-1:0], {(2 * ssd_pkg::FRAC_BITS){1'b0}}});
				rem_q <= '0;
			end
			C_DIV: begin
				rem_q  <= alu_ge ? alu[DW-1:0] : {rem_q[DW-2:0], quo_q[QW-1]};
				quo_q  <= {quo_q[QW-2:0], alu_ge};
				srem_q <= '0;
				root_q <= '0;
			end
			C_ROOT: begin
				if (cnt_q == CNTW'(ssd_pkg::DEV_W)) begin
					sat_q <= ((quo_q >> XW) != '0);
				end
				srem_q <= alu_ge ? alu[RW-1:0] : rsh[RW-1:0];
				root_q <= {root_q[ssd_pkg::DEV_W-2:0], alu_ge};
				quo_q  <= {quo_q[QW-3:0], 2'b00};
			end
			default: begin
				root_q <= root_q;
			end
		endcase
	end

	assign done = (state_q == C_DONE);
	assign dev  = sat_q ? '1 : root_q;

endmodule

>>> rtl/sample_standard_deviation.sv
// Add-sample transactions: one per cycle while ready, running count/sum/square sum updated in place.
// Finishing transaction: after drain and finish states the result loads with status FEW and
// deviation zero if fewer than two samples, else when the core is done; a shared bit-serial
// add/subtract unit runs the multiplies, the divide and the square root one bit per cycle.
// Not ready meanwhile, nor while an earlier result still holds the output; ready again once the result loads.
// Reset (arst_n low, asynchronous) clears count, sums, sequencers and output valid.
module sample_standard_deviation #(
	parameter int MAX_SAMPLES = ssd_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = ssd_pkg::DEF_SAMPLE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ssd_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output ssd_pkg::result_t result
);

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SUMW = SAMPLE_BITS + CW;
	localparam int SQW  = 2 * SAMPLE_BITS + CW - 1;
	localparam int XW   = (SAMPLE_BITS > ssd_pkg::SAMPLE_W) ? SAMPLE_BITS : ssd_pkg::SAMPLE_W;

	typedef enum logic [3:0] {
		T_RUN   = 4'b0001,
		T_DRAIN = 4'b0010,
		T_FIN   = 4'b0100,
		T_CALC  = 4'b1000
	} tstate_t;

	tstate_t                  state_q;
	logic [CW-1:0]            count_q;
	logic signed [SUMW-1:0]   sum_q;
	logic [SQW-1:0]           sqsum_q;
	logic [SAMPLE_BITS-1:0]   mag_s1;
	logic                     sqv_s1;
	logic                     res_valid_q;
	ssd_pkg::result_t         res_q;

	logic                     accept;
	logic                     add_smp;
	logic                     is_fin;
	logic [XW-1:0]            sx;
	logic [SAMPLE_BITS-1:0]   v;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [2*SAMPLE_BITS-1:0] sqr;
	logic [SUMW-1:0]          summag;
	logic                     few;
	logic                     slot_free;
	logic                     ld_few;
	logic                     clr;
	logic                     core_start;
	logic                     core_take;
	logic                     core_done;
	logic [ssd_pkg::DEV_W-1:0] core_dev;

	assign item_ready = (state_q == T_RUN);
	assign accept     = item_valid && item_ready;
	assign add_smp    = accept && (item.mode == ssd_pkg::MODE_ADD
		|| item.mode == ssd_pkg::MODE_ADD_FIN) && (count_q < CW'(MAX_SAMPLES));
	assign is_fin     = accept && (item.mode == ssd_pkg::MODE_ADD_FIN
		|| item.mode == ssd_pkg::MODE_FIN);

	assign sx  = XW'($unsigned(item.sample));
	assign v   = sx[SAMPLE_BITS-1:0];
	assign mag = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
	assign sqr = mag_s1 * mag_s1;

	assign summag = sum_q[SUMW-1] ? $unsigned(-sum_q) : $unsigned(sum_q);

	assign few        = (count_q < CW'(2));
	assign slot_free  = !res_valid_q || result_ready;
	assign ld_few     = (state_q == T_FIN) && few && slot_free;
	assign core_start = (state_q == T_FIN) && !few;
	assign clr        = ld_few || core_start;
	assign core_take  = (state_q == T_CALC) && core_done && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_RUN;
		end else begin
			unique case (state_q)
				T_RUN: begin
					if (is_fin) begin
						state_q <= T_DRAIN;
					end
				end
				T_DRAIN: begin
					state_q <= T_FIN;
				end
				T_FIN: begin
					if (core_start) begin
						state_q <= T_CALC;
					end else if (ld_few) begin
						state_q <= T_RUN;
					end
				end
				T_CALC: begin
					if (core_take) begin
						state_q <= T_RUN;
					end
				end
				default: begin
					state_q <= T_RUN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			sqv_s1  <= 1'b0;
		end else begin
			sqv_s1 <= add_smp;
			if (clr) begin
				count_q <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
			end else begin
				if (add_smp) begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q + SUMW'($signed(v));
				end
				if (sqv_s1) begin
					sqsum_q <= sqsum_q + SQW'(sqr);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_smp) begin
			mag_s1 <= mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ld_few || core_take) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_few) begin
			res_q.deviation <= '0;
			res_q.status    <= ssd_pkg::STATUS_FEW;
		end else if (core_take) begin
			res_q.deviation <= core_dev;
			res_q.status    <= ssd_pkg::STATUS_OK;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	ssd_core #(
		.CW   (CW),
		.SUMW (SUMW),
		.SQW  (SQW)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.take   (core_take),
		.n      (count_q),
		.sqsum  (sqsum_q),
		.summag (summag),
		.done   (core_done),
		.dev    (core_dev)
	);

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam logic [ssd_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 250;
	localparam int ITEMS_PER_PHASE = 335;

	typedef enum int {SPREAD_FULL, SPREAD_EXTREME, SPREAD_NARROW, SPREAD_FLAT} spread_t;

	class sd_scoreboard;
		logic [16:0]        n_samples;
		logic signed [32:0] sum_acc;
		logic [47:0]        sq_acc;
		ssd_pkg::result_t   pending[$];
		int                 errors;

		function new();
			n_samples = '0;
			sum_acc = '0;
			sq_acc = '0;
			errors = 0;
		endfunction

		function void note_item(ssd_pkg::item_t it);
			logic signed [31:0] sv;
			logic [31:0]        sqv;
			logic [63:0]        mag;
			logic [127:0]       numer;
			logic [127:0]       denom;
			logic [127:0]       quot;
			logic [23:0]        root;
			logic [23:0]        trial;
			ssd_pkg::result_t   res;
			if (it.mode == MODE_NONE)
				return;
			if (it.mode != ssd_pkg::MODE_FIN && n_samples < ssd_pkg::DEF_MAX_SAMPLES) begin
				sv = it.sample;
				sqv = sv * sv;
				n_samples = n_samples + 17'd1;
				sum_acc = sum_acc + 33'(sv);
				sq_acc = sq_acc + 48'(sqv);
			end
			if (it.mode == ssd_pkg::MODE_ADD)
				return;
			if (n_samples < 17'd2) begin
				res.deviation = '0;
				res.status = ssd_pkg::STATUS_FEW;
			end else begin
				mag = (sum_acc < 0) ? 64'(-sum_acc) : 64'(sum_acc);
				numer = 128'(n_samples) * 128'(sq_acc) - 128'(mag) * 128'(mag);
				numer = numer << 16;
				denom = 128'(n_samples) * 128'(n_samples - 17'd1);
				quot = numer / denom;
				if (quot >= (128'd1 << 48)) begin
					root = 24'hFFFFFF;
				end else begin
					root = '0;
					for (int b = 23; b >= 0; b--) begin
						trial = root | (24'd1 << b);
						if (48'(trial) * 48'(trial) <= quot[47:0])
							root = trial;
					end
				end
				res.deviation = root;
				res.status = ssd_pkg::STATUS_OK;
			end
			pending = {pending, res};
			n_samples = '0;
			sum_acc = '0;
			sq_acc = '0;
		endfunction

		function void check_result(ssd_pkg::result_t r);
			ssd_pkg::result_t w;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: deviation %0d status %0d",
					$time, r.deviation, r.status);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (r.deviation !== w.deviation) begin
				$display("%0t deviation mismatch: expected %0d actual %0d",
					$time, w.deviation, r.deviation);
				errors++;
			end
			if (r.status !== w.status) begin
				$display("%0t status mismatch: expected %0d actual %0d",
					$time, w.status, r.status);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	ssd_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	ssd_pkg::result_t result;

	sd_scoreboard sb = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int quiet_cycles = 0;

	sample_standard_deviation dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(input logic [ssd_pkg::MODE_W-1:0] m,
		input logic signed [ssd_pkg::SAMPLE_W-1:0] s);
		ssd_pkg::item_t it;
		it.mode = m;
		it.sample = s;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.note_item(it);
		if (m != MODE_NONE)
			sent++;
	endtask

	function automatic logic signed [ssd_pkg::SAMPLE_W-1:0] pick_sample(spread_t sp,
		logic signed [ssd_pkg::SAMPLE_W-1:0] base);
		case (sp)
			SPREAD_EXTREME: return $urandom_range(1) ? -16'sd32768 : 16'sd32767;
			SPREAD_NARROW:  return base + 16'($urandom_range(15)) - 16'sd8;
			SPREAD_FLAT:    return base;
			default:        return 16'($urandom);
		endcase
	endfunction

	task automatic send_run(input int len);
		spread_t sp;
		logic signed [ssd_pkg::SAMPLE_W-1:0] base;
		sp = spread_t'($urandom_range(3));
		base = 16'($urandom);
		for (int k = 0; k < len; k++) begin
			send_item(ssd_pkg::MODE_ADD, pick_sample(sp, base));
			if ($urandom_range(19) == 0)
				send_item(MODE_NONE, 16'($urandom));
		end
		if ($urandom_range(1))
			send_item(ssd_pkg::MODE_ADD_FIN, pick_sample(sp, base));
		else
			send_item(ssd_pkg::MODE_FIN, 16'($urandom));
	endtask

	task automatic run_directed();
		send_item(ssd_pkg::MODE_FIN, 16'sd0);
		send_item(ssd_pkg::MODE_ADD_FIN, 16'sd32767);
		send_item(MODE_NONE, -16'sd1);
		send_item(ssd_pkg::MODE_ADD, -16'sd32768);
		send_item(MODE_NONE, 16'sd12345);
		send_item(ssd_pkg::MODE_ADD_FIN, 16'sd32767);
		send_item(ssd_pkg::MODE_ADD, 16'sd0);
		send_item(ssd_pkg::MODE_ADD, 16'sd0);
		send_item(ssd_pkg::MODE_FIN, -16'sd1);
		repeat (3) send_item(ssd_pkg::MODE_ADD, -16'sd32768);
		send_item(ssd_pkg::MODE_ADD_FIN, -16'sd32768);
		send_item(ssd_pkg::MODE_ADD, 16'sd1);
		send_item(ssd_pkg::MODE_FIN, 16'sd0);
		send_item(ssd_pkg::MODE_ADD, -16'sd1);
		send_item(ssd_pkg::MODE_ADD, 16'sd1);
		send_item(ssd_pkg::MODE_ADD_FIN, 16'sd0);
		send_item(MODE_NONE, -16'sd1);
		send_item(ssd_pkg::MODE_FIN, 16'sd0);
		send_item(ssd_pkg::MODE_ADD, 16'sh5555);
		send_item(ssd_pkg::MODE_ADD_FIN, -16'sh5556);
	endtask

	initial begin
		int len;
		int target;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			target = sent + ITEMS_PER_PHASE;
			if (ph == 0) begin
				run_directed();
				target = sent + ITEMS_PER_PHASE;
			end
			while (sent < target) begin
				if ($urandom_range(7) == 0)
					len = $urandom_range(200);
				else if ($urandom_range(5) == 0)
					len = $urandom_range(1);
				else
					len = $urandom_range(12);
				send_run(len);
			end
		end
		item_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/ssd_pkg.sv
rtl/ssd_core.sv
rtl/sample_standard_deviation.sv
tb/sv/tb.sv
